// ===== rtl/dfc_pkg.sv =====
`timescale 1ns / 1ps
// dfc_pkg: shared types and constants for the delay feedback conditioner
// no dependencies

package dfc_pkg;

  localparam int SampleW = 32;
  localparam int GainW   = 31;
  localparam int CfgIdxW = 2;
  localparam int HpfShift = 11;

  // saturation bounds of the product high word before scaling, 29 signed bits
  localparam int SatBits = SampleW - 3;
  localparam logic signed [SampleW-1:0] SatMax = SampleW'((64'sd1 <<< (SatBits - 1)) - 1);
  localparam logic signed [SampleW-1:0] SatMin = -SampleW'(64'sd1 <<< (SatBits - 1));
  localparam int OutShift = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDelayEnable = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFeedbackGain = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPingPong = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgStereoRender = 2'd3;

  typedef logic signed [SampleW-1:0] sample_t;

  typedef struct packed {
    logic             delay_enable;
    logic [GainW-1:0] feedback_gain;
    logic             ping_pong;
    logic             stereo_render;
  } cfg_t;

  typedef struct packed {
    logic load_mul;
    logic load_hpf;
    logic enable;
  } lane_ctl_t;

endpackage

// ===== rtl/dfc_if.sv =====
`timescale 1ns / 1ps
// dfc_in_if, dfc_out_if: valid/ready channels for input and result items
// depends on dfc_pkg

interface dfc_in_if;
  logic             valid;
  logic             ready;
  dfc_pkg::sample_t delayed_left;
  dfc_pkg::sample_t delayed_right;
  dfc_pkg::sample_t dry_left;
  dfc_pkg::sample_t dry_right;

  modport source (output valid, delayed_left, delayed_right, dry_left, dry_right,
                  input ready);
  modport sink (input valid, delayed_left, delayed_right, dry_left, dry_right,
                output ready);
endinterface

interface dfc_out_if;
  logic             valid;
  logic             ready;
  dfc_pkg::sample_t out_left;
  dfc_pkg::sample_t out_right;
  dfc_pkg::sample_t feed_left;
  dfc_pkg::sample_t feed_right;

  modport source (output valid, out_left, out_right, feed_left, feed_right,
                  input ready);
  modport sink (input valid, out_left, out_right, feed_left, feed_right,
                output ready);
endinterface

// ===== rtl/dfc_lane.sv =====
`timescale 1ns / 1ps
// dfc_lane: one channel of gain scaling, saturation and dc blocking
// depends on dfc_pkg

module dfc_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dfc_pkg::lane_ctl_t            ctl_i,
  input  logic [dfc_pkg::GainW-1:0]     gain_i,
  input  dfc_pkg::sample_t              delayed_i,
  output dfc_pkg::sample_t              wet_o
);

  logic signed [2*dfc_pkg::SampleW-1:0] prod;
  dfc_pkg::sample_t hi_q;
  dfc_pkg::sample_t sat;
  dfc_pkg::sample_t scaled;
  dfc_pkg::sample_t delta;
  dfc_pkg::sample_t acc_q, acc_d;
  dfc_pkg::sample_t wet_q;

  // signed sample times unsigned gain, high word kept
  assign prod = $signed(delayed_i) * $signed({1'b0, gain_i});

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_mul) begin
      hi_q <= prod[2*dfc_pkg::SampleW-1:dfc_pkg::SampleW];
    end
  end

  always_comb begin
    priority if (hi_q > dfc_pkg::SatMax) begin
      sat = dfc_pkg::SatMax;
    end else if (hi_q < dfc_pkg::SatMin) begin
      sat = dfc_pkg::SatMin;
    end else begin
      sat = hi_q;
    end
    scaled = sat <<< dfc_pkg::OutShift;
    delta  = scaled - acc_q;
    acc_d  = acc_q + (delta >>> dfc_pkg::HpfShift);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctl_i.load_hpf && ctl_i.enable) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_hpf) begin
      wet_q <= scaled - acc_d;
    end
  end

  assign wet_o = wet_q;

endmodule

// ===== rtl/dfc_merge.sv =====
`timescale 1ns / 1ps
// dfc_merge: combines both lanes with the dry pair into output and feedback
// depends on dfc_pkg

module dfc_merge (
  input  logic             clk_i,
  input  logic             load_i,
  input  dfc_pkg::cfg_t    cfg_i,
  input  dfc_pkg::sample_t dry_left_i,
  input  dfc_pkg::sample_t dry_right_i,
  input  dfc_pkg::sample_t wet_left_i,
  input  dfc_pkg::sample_t wet_right_i,
  output dfc_pkg::sample_t out_left_o,
  output dfc_pkg::sample_t out_right_o,
  output dfc_pkg::sample_t feed_left_o,
  output dfc_pkg::sample_t feed_right_o
);

  dfc_pkg::sample_t mix_l, mix_r, dry_sum;
  dfc_pkg::sample_t out_l_d, out_r_d, feed_l_d, feed_r_d;
  dfc_pkg::sample_t out_l_q, out_r_q, feed_l_q, feed_r_q;

  always_comb begin
    mix_l   = dry_left_i + wet_left_i;
    mix_r   = dry_right_i + wet_right_i;
    dry_sum = dry_left_i + dry_right_i;
    if (!cfg_i.delay_enable) begin
      out_l_d  = dry_left_i;
      out_r_d  = dry_right_i;
      feed_l_d = '0;
      feed_r_d = '0;
    end else if (cfg_i.ping_pong && cfg_i.stereo_render) begin
      out_l_d  = mix_l;
      out_r_d  = mix_r;
      feed_l_d = wet_right_i;
      feed_r_d = (dry_sum >>> 1) + wet_left_i;
    end else begin
      out_l_d  = mix_l;
      out_r_d  = mix_r;
      feed_l_d = mix_l;
      feed_r_d = mix_r;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      out_l_q  <= out_l_d;
      out_r_q  <= out_r_d;
      feed_l_q <= feed_l_d;
      feed_r_q <= feed_r_d;
    end
  end

  assign out_left_o   = out_l_q;
  assign out_right_o  = out_r_q;
  assign feed_left_o  = feed_l_q;
  assign feed_right_o = feed_r_q;

endmodule

// ===== rtl/delay_feedback_conditioner_top.sv =====
`timescale 1ns / 1ps
// delay_feedback_conditioner_top: two gain/dc-block lanes and a merge stage
// depends on dfc_pkg, dfc_if, dfc_lane, dfc_merge

// usage
// in_if carries one item: a stereo pair read from the delay line and a dry
// stereo pair. out_if returns one item per input: dry plus wet (dry alone
// while delay is disabled) and the pair to write back into the delay line.
// registers are written through cfg_we_i, cfg_idx_i and cfg_data_i; the user
// must write them only while no item is in flight; the block does not check.
// an accepted item passes the multiplier stage, saturation and dc-block
// stage, merge and output register. throughput is one item per cycle while
// the receiver is ready; the lane accumulators update in the dc-block stage.
// reset clears all stage valids, both dc accumulators and the registers to
// their defaults (stereo_render set, all others clear).
// when the receiver stalls, each stage holds its item and empty stages
// upstream keep filling, so new items are taken until the pipe is full.

module delay_feedback_conditioner_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  dfc_in_if.sink                         in_if,
  dfc_out_if.source                      out_if,
  input  logic                           cfg_we_i,
  input  logic [dfc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [dfc_pkg::GainW-1:0]      cfg_data_i
);

  dfc_pkg::cfg_t cfg_q;
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  logic accept, load2, load3;
  dfc_pkg::sample_t dry1_l_q, dry1_r_q, dry2_l_q, dry2_r_q;
  dfc_pkg::sample_t wet_l, wet_r;
  dfc_pkg::lane_ctl_t lane_ctl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delay_enable  <= 1'b0;
      cfg_q.feedback_gain <= '0;
      cfg_q.ping_pong     <= 1'b0;
      cfg_q.stereo_render <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dfc_pkg::CfgDelayEnable:  cfg_q.delay_enable  <= cfg_data_i[0];
        dfc_pkg::CfgFeedbackGain: cfg_q.feedback_gain <= cfg_data_i;
        dfc_pkg::CfgPingPong:     cfg_q.ping_pong     <= cfg_data_i[0];
        dfc_pkg::CfgStereoRender: cfg_q.stereo_render <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign rdy3   = !v3_q || out_if.ready;
  assign rdy2   = !v2_q || rdy3;
  assign rdy1   = !v1_q || rdy2;
  assign accept = in_if.valid && rdy1;
  assign load2  = v1_q && rdy2;
  assign load3  = v2_q && rdy3;

  assign in_if.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept || (v1_q && !rdy2);
      v2_q <= load2 || (v2_q && !rdy3);
      v3_q <= load3 || (v3_q && !out_if.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dry1_l_q <= in_if.dry_left;
      dry1_r_q <= in_if.dry_right;
    end
    if (load2) begin
      dry2_l_q <= dry1_l_q;
      dry2_r_q <= dry1_r_q;
    end
  end

  assign lane_ctl.load_mul = accept;
  assign lane_ctl.load_hpf = load2;
  assign lane_ctl.enable   = cfg_q.delay_enable;

  dfc_lane u_lane_l (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (lane_ctl),
    .gain_i    (cfg_q.feedback_gain),
    .delayed_i (in_if.delayed_left),
    .wet_o     (wet_l)
  );

  dfc_lane u_lane_r (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (lane_ctl),
    .gain_i    (cfg_q.feedback_gain),
    .delayed_i (in_if.delayed_right),
    .wet_o     (wet_r)
  );

  dfc_merge u_merge (
    .clk_i        (clk_i),
    .load_i       (load3),
    .cfg_i        (cfg_q),
    .dry_left_i   (dry2_l_q),
    .dry_right_i  (dry2_r_q),
    .wet_left_i   (wet_l),
    .wet_right_i  (wet_r),
    .out_left_o   (out_if.out_left),
    .out_right_o  (out_if.out_right),
    .feed_left_o  (out_if.feed_left),
    .feed_right_o (out_if.feed_right)
  );

  assign out_if.valid = v3_q;

endmodule

// ===== rtl/dfc_checker.sv =====
`timescale 1ns / 1ps
// dfc_checker: port-level checks for the delay feedback conditioner
// depends on dfc_pkg; bound to delay_feedback_conditioner_top

module dfc_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input dfc_pkg::sample_t out_left,
  input dfc_pkg::sample_t feed_left
);

  // an empty output means the whole pipe can take an item
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input not ready while output is empty");

  // with the receiver ready, an accepted item comes out of the merge register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("item not delivered within pipeline latency");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_left)
                                   && $stable(feed_left)))
    else $error("stalled result changed");

  // no result right after reset release
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid)
    else $error("result valid out of reset");

endmodule

bind delay_feedback_conditioner_top dfc_checker u_dfc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_left  (out_if.out_left),
  .feed_left (out_if.feed_left)
);
